/* rtl/gnorm_pkg.sv */
// Shared types and constants of the Godunov upwind gradient magnitude block.
package gnorm_pkg;

    // Number format and register reset values
    localparam int          FRAC_BITS_DEF     = 16;
    localparam logic [31:0] INV_CELL_SIZE_RST = 32'h0001_0000;
    localparam logic [30:0] CLAMP_LIMIT_RST   = 31'h7FFF_FFFF;

    // Configuration port
    localparam int   APB_ADDR_W    = 3;
    localparam logic REG_INV_CELL  = 1'b0;
    localparam logic REG_CLAMP_LIM = 1'b1;

    // Square root pipeline: one result bit per step
    localparam int SQRT_BITS   = 32;
    localparam int SQRT_STEPS  = 2;
    localparam int SQRT_STAGES = SQRT_BITS / SQRT_STEPS;
    localparam int SQRT_TOP    = 2 * SQRT_BITS - 2;

    // Flags that travel alongside the radicand
    typedef struct packed {
        logic sat;
        logic bnd;
    } t_side;

endpackage

/* rtl/gnorm_isqrt.sv */
// Pipelined 64-bit integer square root, two result bits per stage.
module gnorm_isqrt (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [63:0]           i_radicand,
    input  gnorm_pkg::t_side      i_side,
    output logic                  o_valid,
    output logic [31:0]           o_root,
    output gnorm_pkg::t_side      o_side
);
    import gnorm_pkg::*;

    logic [63:0] w_n   [0:SQRT_STAGES];
    logic [63:0] w_res [0:SQRT_STAGES];
    logic        w_vld [0:SQRT_STAGES];
    t_side       w_side[0:SQRT_STAGES];

    logic [63:0] r_n   [0:SQRT_STAGES-1];
    logic [63:0] r_res [0:SQRT_STAGES-1];
    logic        r_vld [0:SQRT_STAGES-1];
    t_side       r_side[0:SQRT_STAGES-1];

    logic [63:0] n_n   [0:SQRT_STAGES-1];
    logic [63:0] n_res [0:SQRT_STAGES-1];

    assign w_n[0]    = i_radicand;
    assign w_res[0]  = 64'd0;
    assign w_vld[0]  = i_valid;
    assign w_side[0] = i_side;

    for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
        always_comb begin : p_step
            logic [63:0] rem;
            logic [63:0] root;
            logic [63:0] bitv;
            logic [63:0] trial;
            rem  = w_n[s];
            root = w_res[s];
            for (int j = 0; j < SQRT_STEPS; j++) begin
                bitv  = 64'd1 << (SQRT_TOP - 2 * (s * SQRT_STEPS + j));
                trial = root + bitv;
                if (rem >= trial) begin
                    rem  = rem - trial;
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
            end
            n_n[s]   = rem;
            n_res[s] = root;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[s]    <= n_n[s];
                r_res[s]  <= n_res[s];
                r_side[s] <= w_side[s];
            end
        end

        assign w_n[s+1]    = r_n[s];
        assign w_res[s+1]  = r_res[s];
        assign w_vld[s+1]  = r_vld[s];
        assign w_side[s+1] = r_side[s];
    end

    assign o_valid = w_vld[SQRT_STAGES];
    assign o_root  = w_res[SQRT_STAGES][31:0];
    assign o_side  = w_side[SQRT_STAGES];

endmodule

/* rtl/godunov_gradient_norm_unit.sv */
// Top level: Godunov upwind gradient magnitude of one level-set cell per cycle while not stalled.
//
// Takes one cell request per cycle while o_stall is low and passes it through
// seven front stages (clamp, differences, upwind pick, scaling multiply, shift
// and range check, squaring, three-axis sum), a 16-stage square root settling
// two result bits per stage, and an output register. Each axis uses one 32x32
// multiplier for scaling and one for squaring. The whole pipeline holds while a
// finished result waits under i_stall, so o_stall follows i_stall only when the
// output register is full. Configuration must be written by the user through
// the APB port only while no request is in flight; the block has no check.
module godunov_gradient_norm_unit #(
    parameter int FRAC_BITS = gnorm_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gnorm_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // cell requests
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [31:0]                i_center_phi,
    input  logic signed [31:0]                i_west_phi,
    input  logic signed [31:0]                i_east_phi,
    input  logic signed [31:0]                i_south_phi,
    input  logic signed [31:0]                i_north_phi,
    input  logic signed [31:0]                i_below_phi,
    input  logic signed [31:0]                i_above_phi,
    input  logic                              i_sign_negative,
    input  logic                              i_on_boundary,
    // results
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [31:0]                       o_grad_norm
);
    import gnorm_pkg::*;

    localparam logic [31:0] ONE_VAL = 32'd1 << FRAC_BITS;

    // ---------------- configuration registers ----------------
    logic [31:0] r_inv_cell_size;
    logic [30:0] r_clamp_limit;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_cell_size <= INV_CELL_SIZE_RST;
            r_clamp_limit   <= CLAMP_LIMIT_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_INV_CELL:  r_inv_cell_size <= pwdata;
                REG_CLAMP_LIM: r_clamp_limit   <= pwdata[30:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_INV_CELL:  prdata = r_inv_cell_size;
            REG_CLAMP_LIM: prdata = {1'b0, r_clamp_limit};
            default:       prdata = 32'd0;
        endcase
    end

    // ---------------- flow control ----------------
    logic r_out_valid;
    logic en;

    assign o_stall = r_out_valid && i_stall;
    assign en      = !o_stall;

    // ---------------- stage 1: clamp ----------------
    logic signed [31:0] in_phi [0:6];
    logic signed [31:0] n_phi1 [0:6];
    logic signed [31:0] r_phi1 [0:6];
    logic               r_v1, r_neg1, r_bnd1;

    assign in_phi[0] = i_center_phi;
    assign in_phi[1] = i_west_phi;
    assign in_phi[2] = i_east_phi;
    assign in_phi[3] = i_south_phi;
    assign in_phi[4] = i_north_phi;
    assign in_phi[5] = i_below_phi;
    assign in_phi[6] = i_above_phi;

    always_comb begin : p_clamp
        logic signed [32:0] lim;
        logic signed [32:0] nlim;
        logic signed [32:0] v;
        lim  = signed'({2'b00, r_clamp_limit});
        nlim = -lim;
        for (int k = 0; k < 7; k++) begin
            v = 33'(in_phi[k]);
            if (v > lim) begin
                n_phi1[k] = lim[31:0];
            end else if (v < nlim) begin
                n_phi1[k] = nlim[31:0];
            end else begin
                n_phi1[k] = in_phi[k];
            end
        end
    end

    // ---------------- stage 2: differences ----------------
    logic signed [32:0] n_back2 [0:2];
    logic signed [32:0] n_fwd2  [0:2];
    logic signed [32:0] r_back2 [0:2];
    logic signed [32:0] r_fwd2  [0:2];
    logic               r_v2, r_neg2, r_bnd2;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_back2[a] = 33'(r_phi1[0]) - 33'(r_phi1[2*a+1]);
            n_fwd2[a]  = 33'(r_phi1[2*a+2]) - 33'(r_phi1[0]);
        end
    end

    // ---------------- stage 3: upwind pick ----------------
    function automatic logic [31:0] pick_pos(input logic signed [32:0] d);
        return (!d[32] && (d != 33'sd0)) ? d[31:0] : 32'd0;
    endfunction

    function automatic logic [31:0] pick_neg(input logic signed [32:0] d);
        logic signed [32:0] nd;
        nd = -d;
        return d[32] ? nd[31:0] : 32'd0;
    endfunction

    logic [31:0] n_mag3 [0:2];
    logic [31:0] r_mag3 [0:2];
    logic        r_v3, r_bnd3;

    // Scaling is monotone, so keeping the larger raw magnitude is enough.
    always_comb begin : p_pick
        logic [31:0] ma;
        logic [31:0] mb;
        for (int a = 0; a < 3; a++) begin
            ma = r_neg2 ? pick_neg(r_back2[a]) : pick_pos(r_back2[a]);
            mb = r_neg2 ? pick_pos(r_fwd2[a])  : pick_neg(r_fwd2[a]);
            n_mag3[a] = (ma > mb) ? ma : mb;
        end
    end

    // ---------------- stage 4: scaling multiply ----------------
    logic [63:0] r_prod4 [0:2];
    logic        r_v4, r_bnd4;

    // ---------------- stage 5: shift and range check ----------------
    logic [63:0] scl [0:2];
    logic [31:0] r_scl5 [0:2];
    logic        r_sat5, r_v5, r_bnd5;
    logic        n_sat5;

    always_comb begin
        n_sat5 = 1'b0;
        for (int a = 0; a < 3; a++) begin
            scl[a] = r_prod4[a] >> FRAC_BITS;
            n_sat5 = n_sat5 | (scl[a][63:32] != 32'd0);
        end
    end

    // ---------------- stage 6: squares ----------------
    logic [63:0] r_sq6 [0:2];
    logic        r_sat6, r_v6, r_bnd6;

    // ---------------- stage 7: sum ----------------
    logic [65:0] sum66;
    logic [63:0] r_sum7;
    t_side       r_side7;
    logic        r_v7;

    assign sum66 = 66'(r_sq6[0]) + 66'(r_sq6[1]) + 66'(r_sq6[2]);

    // ---------------- pipeline registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_phi1  <= n_phi1;
            r_neg1  <= i_sign_negative;
            r_bnd1  <= i_on_boundary;

            r_back2 <= n_back2;
            r_fwd2  <= n_fwd2;
            r_neg2  <= r_neg1;
            r_bnd2  <= r_bnd1;

            r_mag3  <= n_mag3;
            r_bnd3  <= r_bnd2;

            for (int a = 0; a < 3; a++) begin
                r_prod4[a] <= 64'(r_mag3[a]) * 64'(r_inv_cell_size);
                r_scl5[a]  <= scl[a][31:0];
                r_sq6[a]   <= 64'(r_scl5[a]) * 64'(r_scl5[a]);
            end
            r_bnd4  <= r_bnd3;

            r_sat5  <= n_sat5;
            r_bnd5  <= r_bnd4;

            r_sat6  <= r_sat5;
            r_bnd6  <= r_bnd5;

            r_sum7      <= sum66[63:0];
            r_side7.sat <= r_sat6 | (sum66[65:64] != 2'b00);
            r_side7.bnd <= r_bnd6;
        end
    end

    // ---------------- square root ----------------
    logic        sq_valid;
    logic [31:0] sq_root;
    t_side       sq_side;

    gnorm_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_v7),
        .i_radicand (r_sum7),
        .i_side     (r_side7),
        .o_valid    (sq_valid),
        .o_root     (sq_root),
        .o_side     (sq_side)
    );

    // ---------------- output register ----------------
    logic [31:0] r_grad_norm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (sq_side.bnd) begin
                r_grad_norm <= ONE_VAL;
            end else if (sq_side.sat) begin
                r_grad_norm <= 32'hFFFF_FFFF;
            end else begin
                r_grad_norm <= sq_root;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_grad_norm = r_grad_norm;

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench of the Godunov upwind gradient magnitude unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gnorm_pkg::*;

    localparam int          FRAC       = FRAC_BITS_DEF;
    localparam int          CYCLE_CAP  = 600_000;
    localparam int          RAND_CELLS = 1290;
    localparam int          PHASES     = 6;
    localparam logic [31:0] ZERO       = 32'h0000_0000;
    localparam logic [31:0] ONE        = 32'd1 << FRAC;
    localparam logic [31:0] PHI_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] PHI_MIN    = 32'h8000_0000;
    localparam logic [31:0] SAT        = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] center;
        logic [31:0] west;
        logic [31:0] east;
        logic [31:0] south;
        logic [31:0] north;
        logic [31:0] below;
        logic [31:0] above;
        logic        neg;
        logic        bnd;
    } t_cell;

    typedef enum logic {ROW_CELL, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic        sel;
        logic [31:0] cfg;
        t_cell       req;
        logic        known;
        logic [31:0] want;
    } t_row;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [31:0]           pwdata  = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    t_cell                 drv     = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [31:0]           o_grad_norm;

    // Predictor copy of the configuration
    logic [31:0] inv_scale = INV_CELL_SIZE_RST;
    logic [30:0] clamp_mag = CLAMP_LIMIT_RST;

    logic [31:0] norm_q [$];
    int          fail_count  = 0;
    int          cycle_count = 0;
    int          tx_calm     = 0;
    int          rx_busy     = 0;
    int          rx_calm     = 0;

    godunov_gradient_norm_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_center_phi   (drv.center),
        .i_west_phi     (drv.west),
        .i_east_phi     (drv.east),
        .i_south_phi    (drv.south),
        .i_north_phi    (drv.north),
        .i_below_phi    (drv.below),
        .i_above_phi    (drv.above),
        .i_sign_negative(drv.neg),
        .i_on_boundary  (drv.bnd),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_grad_norm    (o_grad_norm)
    );

    always #4 i_clk = ~i_clk;

    function automatic longint clip_phi(logic [31:0] raw);
        longint lim;
        longint v;
        lim = longint'(clamp_mag);
        v   = longint'($signed(raw));
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic logic [63:0] scaled(longint diff);
        logic [63:0] mag;
        mag = (diff < 0) ? 64'(-diff) : 64'(diff);
        return (mag * {32'd0, inv_scale}) >> FRAC;
    endfunction

    // Keep the larger of the upwind backward and forward magnitudes on one axis
    function automatic logic [63:0] axis_keep(longint lo, longint mid, longint hi, logic neg);
        longint      back;
        longint      fwd;
        logic [63:0] a;
        logic [63:0] b;
        back = mid - lo;
        fwd  = hi - mid;
        a = (neg ? back < 0 : back > 0) ? scaled(back) : 64'd0;
        b = (neg ? fwd > 0 : fwd < 0) ? scaled(fwd) : 64'd0;
        return (a > b) ? a : b;
    endfunction

    function automatic logic [31:0] upwind_norm(t_cell c);
        longint      mid;
        logic [63:0] keep [3];
        logic [65:0] sum;
        logic [63:0] trial;
        logic [31:0] root;
        if (c.bnd) return ONE;
        mid     = clip_phi(c.center);
        keep[0] = axis_keep(clip_phi(c.west), mid, clip_phi(c.east), c.neg);
        keep[1] = axis_keep(clip_phi(c.south), mid, clip_phi(c.north), c.neg);
        keep[2] = axis_keep(clip_phi(c.below), mid, clip_phi(c.above), c.neg);
        sum = '0;
        foreach (keep[k]) begin
            if (keep[k] > 64'(SAT)) return SAT;
            sum += 66'(keep[k] * keep[k]);
        end
        if (sum[65:64] != 2'b00) return SAT;
        // Settle the root one bit at a time from the top
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = 64'(root | (32'd1 << b));
            if (66'(trial * trial) <= sum) root = trial[31:0];
        end
        return root;
    endfunction

    function automatic t_row cfg_row(logic sel, logic [31:0] value);
        t_row r;
        r      = '0;
        r.kind = ROW_CFG;
        r.sel  = sel;
        r.cfg  = value;
        return r;
    endfunction

    function automatic t_row cell_row(logic [31:0] c, logic [31:0] w, logic [31:0] e,
                                      logic [31:0] s, logic [31:0] n, logic [31:0] b,
                                      logic [31:0] a, logic neg, logic bnd,
                                      logic known = 1'b0, logic [31:0] want = '0);
        t_row r;
        r       = '0;
        r.kind  = ROW_CELL;
        r.req   = '{c, w, e, s, n, b, a, neg, bnd};
        r.known = known;
        r.want  = want;
        return r;
    endfunction

    function automatic logic [31:0] near(logic [31:0] mid);
        return mid + 32'(int'($urandom()) >>> $urandom_range(4, 31));
    endfunction

    function automatic logic [31:0] extreme();
        case ($urandom_range(0, 5))
            0: return PHI_MIN;
            1: return PHI_MAX;
            2: return ZERO;
            3: return ONE;
            4: return 32'hFFFF_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_cell rand_cell();
        t_cell c;
        int    mode;
        mode = $urandom_range(0, 9);
        if (mode < 2 || mode == 9) begin
            c = '{$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                  $urandom(), $urandom(), 1'b0, 1'b0};
        end else if (mode < 8) begin
            // Smooth field: neighbors close to the center
            c.center = 32'(int'($urandom()) >>> $urandom_range(0, 16));
            c.west   = near(c.center);
            c.east   = near(c.center);
            c.south  = near(c.center);
            c.north  = near(c.center);
            c.below  = near(c.center);
            c.above  = near(c.center);
        end else begin
            c = '{extreme(), extreme(), extreme(), extreme(), extreme(),
                  extreme(), extreme(), 1'b0, 1'b0};
        end
        c.neg = 1'($urandom_range(0, 1));
        c.bnd = (mode == 9) || ($urandom_range(0, 19) == 0);
        return c;
    endfunction

    function automatic int next_gap();
        int r;
        if (tx_calm > 0) begin
            tx_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 80) return $urandom_range(1, 3);
        if (r < 92) return $urandom_range(6, 30);
        tx_calm = $urandom_range(20, 100);
        return 0;
    endfunction

    task automatic apb_xfer(input logic wr, input logic sel, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_ADDR_W'({sel, 2'b00});
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_check(input logic sel, input logic [31:0] held);
        logic [31:0] got;
        apb_xfer(1'b0, sel, '0, got);
        if (got !== held) begin
            $error("register %0d: expected %h, got %h", sel, held, got);
            fail_count++;
        end
    endtask

    task automatic set_reg(input logic sel, input logic [31:0] value);
        logic [31:0] unused;
        apb_xfer(1'b1, sel, value, unused);
        if (sel == REG_INV_CELL) begin
            inv_scale = value;
            read_check(sel, value);
        end else begin
            clamp_mag = value[30:0];
            read_check(sel, {1'b0, value[30:0]});
        end
    endtask

    // Drop valid and hold off until every expected result has come back
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (norm_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic push_cell(input t_cell c, input logic known, input logic [31:0] want);
        int gap;
        @(negedge i_clk);
        i_valid <= 1'b1;
        drv     <= c;
        do @(posedge i_clk); while (o_stall);
        norm_q.insert(norm_q.size(), known ? want : upwind_norm(c));
        gap = next_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    always @(negedge i_clk) begin : rx_pace
        int   r;
        logic nxt;
        if (rx_busy > 0) begin
            rx_busy--;
            nxt = 1'b1;
        end else if (rx_calm > 0) begin
            rx_calm--;
            nxt = 1'b0;
        end else begin
            r   = $urandom_range(0, 99);
            nxt = (r >= 55 && r < 95);
            if (r >= 55 && r < 85) rx_busy = $urandom_range(0, 2);
            else if (r >= 85 && r < 95) rx_busy = $urandom_range(8, 40);
            else if (r >= 95) rx_calm = $urandom_range(20, 120);
        end
        i_stall <= nxt;
    end

    always @(posedge i_clk) begin : result_check
        logic [31:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (norm_q.size() == 0) begin
                $error("grad_norm: unexpected result %h", o_grad_norm);
                fail_count++;
            end else begin
                want = norm_q.pop_front();
                if (o_grad_norm !== want) begin
                    $error("grad_norm: expected %h, got %h", want, o_grad_norm);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        t_row        plan [$];
        logic [31:0] inv_pick;
        logic [31:0] clamp_pick;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        read_check(REG_INV_CELL, INV_CELL_SIZE_RST);
        read_check(REG_CLAMP_LIM, {1'b0, CLAMP_LIMIT_RST});

        plan = '{
            cell_row(ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, 1'b0, 1'b0, 1'b1, ZERO),
            cell_row(ONE, ONE, ONE, ONE, ONE, ONE, ONE, 1'b1, 1'b0, 1'b1, ZERO),
            cell_row(PHI_MIN, 32'h1234_5678, PHI_MAX, 32'hDEAD_BEEF, 32'h0F0F_0F0F,
                     32'hF0F0_F0F0, 32'h8000_0001, 1'b0, 1'b1, 1'b1, ONE),
            cell_row(PHI_MAX, PHI_MAX, PHI_MAX, PHI_MAX, PHI_MAX, PHI_MAX, PHI_MAX,
                     1'b1, 1'b1, 1'b1, ONE),
            // Full-scale step on one axis, then the same step against the sign
            cell_row(PHI_MAX, PHI_MIN, PHI_MAX, PHI_MAX, PHI_MAX, PHI_MAX, PHI_MAX,
                     1'b0, 1'b0, 1'b1, 32'hFFFF_FFFE),
            cell_row(PHI_MAX, PHI_MIN, PHI_MAX, PHI_MAX, PHI_MAX, PHI_MAX, PHI_MAX,
                     1'b1, 1'b0, 1'b1, ZERO),
            cell_row(PHI_MIN, PHI_MIN, PHI_MAX, PHI_MIN, PHI_MIN, PHI_MIN, PHI_MIN,
                     1'b1, 1'b0, 1'b1, 32'hFFFF_FFFE),
            cell_row(PHI_MIN, PHI_MIN, PHI_MAX, PHI_MIN, PHI_MIN, PHI_MIN, PHI_MIN,
                     1'b0, 1'b0, 1'b1, ZERO),
            cell_row(PHI_MAX, PHI_MIN, PHI_MAX, PHI_MIN, PHI_MAX, PHI_MIN, PHI_MAX,
                     1'b0, 1'b0, 1'b1, SAT),
            cell_row(ONE, ZERO, 32'h0002_0000, ONE, ONE, ONE, ONE, 1'b0, 1'b0),
            cell_row(ONE, ZERO, 32'h0002_0000, ONE, ONE, ONE, ONE, 1'b1, 1'b0),
            cell_row(ZERO, ONE, 32'hFFFF_0000, ZERO, ZERO, ZERO, ZERO, 1'b0, 1'b0),
            cell_row(32'h0002_8000, 32'h0001_4000, 32'h0003_0000, 32'h0002_C000,
                     32'h0002_1000, 32'h0002_8001, 32'h0001_FFFF, 1'b0, 1'b0),
            cell_row(32'h0002_8000, 32'h0001_4000, 32'h0003_0000, 32'h0002_C000,
                     32'h0002_1000, 32'h0002_8001, 32'h0001_FFFF, 1'b1, 1'b0),
            cell_row(32'd3, 32'd0, 32'd1, 32'd2, 32'd7, 32'd3, 32'd4, 1'b0, 1'b0),
            cfg_row(REG_INV_CELL, 32'hFFFF_FFFF),
            cell_row(32'd1, ZERO, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 1'b0, 1'b0),
            cell_row(ONE, ZERO, ONE, ONE, ONE, ONE, ONE, 1'b0, 1'b0),
            cell_row(32'h0002_0000, ZERO, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000,
                     32'h0002_0000, 32'h0002_0000, 1'b0, 1'b0, 1'b1, SAT),
            cfg_row(REG_INV_CELL, ZERO),
            cell_row(PHI_MAX, PHI_MIN, PHI_MAX, PHI_MIN, PHI_MAX, PHI_MIN, PHI_MAX,
                     1'b0, 1'b0, 1'b1, ZERO),
            cfg_row(REG_INV_CELL, 32'd1),
            cell_row(PHI_MAX, PHI_MIN, PHI_MAX, PHI_MIN, PHI_MAX, PHI_MIN, PHI_MAX,
                     1'b0, 1'b0),
            cfg_row(REG_INV_CELL, ONE),
            cfg_row(REG_CLAMP_LIM, ZERO),
            cell_row(PHI_MAX, PHI_MIN, 32'h1234_5678, PHI_MIN, PHI_MAX, 32'h8765_4321,
                     ONE, 1'b0, 1'b0, 1'b1, ZERO),
            cfg_row(REG_CLAMP_LIM, ONE),
            cell_row(32'h0005_0000, 32'hFFFB_0000, 32'h0005_0000, 32'h0005_0000,
                     32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 1'b0, 1'b0),
            cell_row(32'hFFF9_0000, 32'hFFF9_0000, 32'h0007_0000, 32'hFFF9_0000,
                     32'hFFF9_0000, 32'hFFF9_0000, 32'hFFF9_0000, 1'b1, 1'b0)
        };

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_CFG) begin
                wait_idle();
                set_reg(plan[r].sel, plan[r].cfg);
            end else begin
                push_cell(plan[r].req, plan[r].known, plan[r].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    inv_pick   = ONE;
                    clamp_pick = PHI_MAX;
                end
                1: begin
                    inv_pick   = 32'hFFFF_FFFF;
                    clamp_pick = $urandom();
                end
                2: begin
                    inv_pick   = 32'd1;
                    clamp_pick = PHI_MAX;
                end
                3: begin
                    inv_pick   = $urandom_range(1, 32'h0010_0000);
                    clamp_pick = $urandom_range(0, 32'h0010_0000);
                end
                4: begin
                    inv_pick   = ONE;
                    clamp_pick = $urandom_range(0, 32'h0004_0000);
                end
                default: begin
                    inv_pick   = $urandom();
                    clamp_pick = $urandom();
                end
            endcase
            wait_idle();
            set_reg(REG_INV_CELL, inv_pick);
            set_reg(REG_CLAMP_LIM, clamp_pick);
            repeat (RAND_CELLS / PHASES) push_cell(rand_cell(), 1'b0, '0);
        end

        wait_idle();
        repeat (30) @(posedge i_clk);
        if (fail_count == 0 && norm_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
